FILE: design/sdkt_pkg.sv
`default_nettype none

package sdkt_pkg;

  localparam int unsigned CAPACITY = 32;

  localparam int unsigned KEY_W   = 63;
  localparam int unsigned PAY_W   = 64;
  localparam int unsigned OWNER_W = 32;
  localparam int unsigned RCNT_W  = 6;
  localparam int unsigned OCC_W   = 6;

  // record count holds 0..CAPACITY
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // common width for comparing read_count against the record count
  localparam int unsigned CMP_W = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_WRONG_OWNER = 3'd1,
    ST_FULL        = 3'd2,
    ST_DUPLICATE   = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_OVERWRITE,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    req_e                 req_type;
    logic [OWNER_W-1:0]   owner_id;
    logic [KEY_W-1:0]     new_key;
    logic [PAY_W-1:0]     new_payload;
    logic                 overwrite;
    logic [RCNT_W-1:0]    read_count;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic                 item_valid;
    logic [KEY_W-1:0]     out_key;
    logic [PAY_W-1:0]     out_payload;
    logic                 last;
    logic [OCC_W-1:0]     occupancy;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } rec_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e op;
    rec_t     rec;
  } cell_ctrl_t;

  // per-cell position relative to the current record count
  typedef struct packed {
    logic occ;
    logic last_occ;
  } cell_pos_t;

  typedef struct packed {
    logic ge;
    logic eq;
    logic gt;
  } cell_cmp_t;

endpackage

`default_nettype wire

FILE: design/sdkt_if.sv
`default_nettype none

interface sdkt_req_if import sdkt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdkt_rsp_if import sdkt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/sorted_descending_key_table_top.sv
// Channel  Dir  Modport             Transaction
// req_i    in   sdkt_req_if.sink    one request: insert, remove, read or clear
// rsp_o    out  sdkt_rsp_if.source  one result; a read gives one per record read, or one if none
//
// Insert, remove and clear finish in the cycle they are accepted.
// A read of no records answers in its accept cycle. Any other read then rotates
// the ring of occupied cells once, one cell per cycle while not stalled, and
// requests stay blocked until the rotation ends; records leave from the head.
// Reset clears record count, owner, controller state and the output queue;
// record contents stay undefined until written.
// A two-entry output queue lets a request in while one result waits; a full
// queue stalls new requests and, while records remain to be sent, the rotation.
`default_nettype none

module sorted_descending_key_table_top import sdkt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sdkt_req_if.sink    req_i,
  sdkt_rsp_if.source  rsp_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [OWNER_W-1:0]  owner_q, owner_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    step_q, step_d;

  cell_ctrl_t          ctrl;
  rec_t                new_rec;
  rec_t                recs [CAPACITY];
  cell_cmp_t           cmps [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic                any_eq;

  logic                room;
  logic                accept;
  logic                push;
  rsp_t                push_data;
  logic [CMP_W-1:0]    rc_ext, cnt_ext;
  logic [CNT_W-1:0]    n_rd;
  logic                step_go;

  assign new_rec.key     = req_i.data.new_key;
  assign new_rec.payload = req_i.data.new_payload;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t      prev_rec;
    rec_t      next_rec;
    logic      prev_ge;
    cell_pos_t pos;

    if (i == 0) begin : g_first
      assign prev_rec = new_rec;
      assign prev_ge  = 1'b1;
    end else begin : g_mid
      assign prev_rec = recs[i-1];
      assign prev_ge  = cmps[i-1].ge;
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_rec = recs[i];
    end else begin : g_body
      assign next_rec = recs[i+1];
    end

    assign pos.occ      = CNT_W'(i) < count_q;
    assign pos.last_occ = CNT_W'(i + 1) == count_q;
    assign eq_vec[i]    = cmps[i].eq;

    sdkt_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .pos_i     (pos),
      .prev_i    (prev_rec),
      .prev_ge_i (prev_ge),
      .next_i    (next_rec),
      .head_i    (recs[0]),
      .rec_o     (recs[i]),
      .cmp_o     (cmps[i])
    );
  end

  assign any_eq = |eq_vec;

  assign rc_ext  = CMP_W'(req_i.data.read_count);
  assign cnt_ext = CMP_W'(count_q);
  // never above count_q, so the cut to CNT_W is safe
  assign n_rd    = (rc_ext < cnt_ext) ? CNT_W'(rc_ext) : count_q;

  assign req_i.ready = (state_q == S_IDLE) && room;
  assign accept      = req_i.valid && req_i.ready;
  assign step_go     = (state_q == S_READ) && ((step_q >= n_q) || room);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    owner_d  = owner_q;
    n_d      = n_q;
    step_d   = step_q;
    ctrl.op  = CELL_HOLD;
    ctrl.rec = new_rec;
    push     = 1'b0;

    push_data.status      = ST_OK;
    push_data.item_valid  = 1'b0;
    push_data.out_key     = '0;
    push_data.out_payload = '0;
    push_data.last        = 1'b1;
    push_data.occupancy   = OCC_W'(count_q);

    if (accept) begin
      push = 1'b1;
      case (req_i.data.req_type)
        REQ_INSERT: begin
          if ((owner_q != '0) && (owner_q != req_i.data.owner_id)) begin
            push_data.status = ST_WRONG_OWNER;
          end else begin
            owner_d = req_i.data.owner_id;
            if (count_q == CNT_W'(CAPACITY)) begin
              push_data.status = ST_FULL;
            end else if (any_eq) begin
              if (req_i.data.overwrite) begin
                ctrl.op = CELL_OVERWRITE;
              end else begin
                push_data.status = ST_DUPLICATE;
              end
            end else begin
              ctrl.op = CELL_INSERT;
              count_d = count_q + CNT_W'(1);
            end
          end
        end
        REQ_REMOVE: begin
          if (any_eq) begin
            ctrl.op = CELL_REMOVE;
            count_d = count_q - CNT_W'(1);
          end else begin
            push_data.status = ST_NOT_FOUND;
          end
        end
        REQ_READ: begin
          if (n_rd != '0) begin
            push    = 1'b0;
            state_d = S_READ;
            n_d     = n_rd;
            step_d  = '0;
          end
        end
        REQ_CLEAR: begin
          count_d = '0;
        end
        default: begin
          push = 1'b1;
        end
      endcase
      push_data.occupancy = OCC_W'(count_d);
    end else if (step_go) begin
      ctrl.op               = CELL_ROTATE;
      push                  = step_q < n_q;
      push_data.item_valid  = 1'b1;
      push_data.out_key     = recs[0].key;
      push_data.out_payload = recs[0].payload;
      push_data.last        = (step_q + CNT_W'(1)) == n_q;
      step_d                = step_q + CNT_W'(1);
      if ((step_q + CNT_W'(1)) == count_q) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      owner_q <= '0;
      n_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      owner_q <= owner_d;
      n_q     <= n_d;
      step_q  <= step_d;
    end
  end

  sdkt_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .rsp_o       (rsp_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_read_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> $stable(count_q))
    else $error("record count changed during read rotation");

  a_record_only_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_data.item_valid) |-> (state_q == S_READ && n_q != '0))
    else $error("record result outside of a read");

  a_read_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && push && push_data.last) |-> (step_q + CNT_W'(1) == n_q))
    else $error("last flag on wrong read record");

endmodule

`default_nettype wire

FILE: design/sdkt_cell.sv
`default_nettype none

module sdkt_cell import sdkt_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire cell_pos_t  pos_i,
  input  wire rec_t       prev_i,
  input  wire logic       prev_ge_i,
  input  wire rec_t       next_i,
  input  wire rec_t       head_i,
  output rec_t            rec_o,
  output cell_cmp_t       cmp_o
);

  rec_t rec_q;
  rec_t rec_d;

  always_comb begin
    cmp_o.ge = pos_i.occ && (rec_q.key >= ctrl_i.rec.key);
    cmp_o.eq = pos_i.occ && (rec_q.key == ctrl_i.rec.key);
    cmp_o.gt = cmp_o.ge && !cmp_o.eq;
  end

  always_comb begin
    rec_d = rec_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        // larger keys stay, the first smaller or empty slot takes the new record,
        // everything behind it moves down one place
        if (!cmp_o.ge) begin
          rec_d = prev_ge_i ? ctrl_i.rec : prev_i;
        end
      end
      CELL_OVERWRITE: begin
        if (cmp_o.eq) begin
          rec_d.payload = ctrl_i.rec.payload;
        end
      end
      CELL_REMOVE: begin
        if (pos_i.occ && !cmp_o.gt) begin
          rec_d = next_i;
        end
      end
      CELL_ROTATE: begin
        // ring over occupied cells only; head wraps to the last one
        if (pos_i.occ) begin
          rec_d = pos_i.last_occ ? head_i : next_i;
        end
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

FILE: design/sdkt_out_queue.sv
`default_nettype none

module sdkt_out_queue import sdkt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire rsp_t      push_data_i,
  output logic           room_o,
  sdkt_rsp_if.source     rsp_o
);

  rsp_t head_q, head_d;
  rsp_t tail_q, tail_d;
  logic head_v_q, head_v_d;
  logic tail_v_q, tail_v_d;
  logic pop;

  assign pop    = head_v_q && rsp_o.ready;
  assign room_o = !tail_v_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    head_v_d = head_v_q;
    tail_v_d = tail_v_q;
    if (pop) begin
      head_d   = tail_q;
      head_v_d = tail_v_q;
      tail_v_d = 1'b0;
    end
    if (push_i) begin
      if (!head_v_d) begin
        head_d   = push_data_i;
        head_v_d = 1'b1;
      end else begin
        tail_d   = push_data_i;
        tail_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      tail_v_q <= tail_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign rsp_o.valid = head_v_q;
  assign rsp_o.data  = head_q;

endmodule

`default_nettype wire
